// File: sv/olis_pkg.sv
package olis_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 8;
	localparam int POS_W    = 6;
	localparam int ACT_W    = 4;

	localparam logic [ACT_W-1:0] ACT_APPEND      = 4'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT      = 4'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE      = 4'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE_LAST = 4'd3;
	localparam logic [ACT_W-1:0] ACT_READ        = 4'd4;
	localparam logic [ACT_W-1:0] ACT_WRITE       = 4'd5;
	localparam logic [ACT_W-1:0] ACT_SEARCH      = 4'd6;
	localparam logic [ACT_W-1:0] ACT_SHUFFLE     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_CLEAR       = 4'd8;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [POS_W-1:0] position_in;
		logic [VAL_W-1:0] value_in;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value_out;
		logic             found;
		logic [POS_W-1:0] position_out;
		logic [CNT_W-1:0] count_out;
		status_t          status;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    issue;
		logic    single_wr;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
		logic    flip;
		logic    finish;
		status_t status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             full;
		logic             empty;
		logic             range;
		logic             few;
		logic             last;
	} dp_stat_t;

endpackage

// File: sv/olis_ctrl.sv
module olis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  olis_pkg::dp_stat_t stat,
	output olis_pkg::dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_SWEEP  = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_FINAL  = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	olis_pkg::status_t st_q, st_d;
	logic              out_vld_q, out_vld_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		st_d    = st_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				st_d    = olis_pkg::ST_OK;
				state_d = S_FIN;
				case (stat.act)
					olis_pkg::ACT_APPEND: begin
						if (stat.full) st_d = olis_pkg::ST_FULL;
						else state_d = S_FINAL;
					end
					olis_pkg::ACT_INSERT: begin
						if (stat.full) st_d = olis_pkg::ST_FULL;
						else if (stat.range) st_d = olis_pkg::ST_RANGE;
						else state_d = S_SWEEP;
					end
					olis_pkg::ACT_REMOVE, olis_pkg::ACT_READ: begin
						if (stat.empty) st_d = olis_pkg::ST_EMPTY;
						else if (stat.range) st_d = olis_pkg::ST_RANGE;
						else state_d = S_SWEEP;
					end
					olis_pkg::ACT_REMOVE_LAST: begin
						if (stat.empty) st_d = olis_pkg::ST_EMPTY;
						else state_d = S_SWEEP;
					end
					olis_pkg::ACT_WRITE: begin
						if (stat.empty) st_d = olis_pkg::ST_EMPTY;
						else if (stat.range) st_d = olis_pkg::ST_RANGE;
						else state_d = S_FINAL;
					end
					olis_pkg::ACT_SEARCH: begin
						if (!stat.empty) state_d = S_SWEEP;
					end
					olis_pkg::ACT_SHUFFLE: begin
						if (!stat.few) state_d = S_SWEEP;
					end
					olis_pkg::ACT_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_SWEEP: begin
				cmd.issue = 1'b1;
				if (stat.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				// last read data lands this cycle
				cmd.flip    = (stat.act == olis_pkg::ACT_SHUFFLE);
				cmd.cnt_dec = stat.act inside {olis_pkg::ACT_REMOVE, olis_pkg::ACT_REMOVE_LAST};
				state_d     = (stat.act == olis_pkg::ACT_INSERT) ? S_FINAL : S_FIN;
			end
			S_FINAL: begin
				cmd.single_wr = 1'b1;
				cmd.cnt_inc   = (stat.act != olis_pkg::ACT_WRITE);
				state_d       = S_FIN;
			end
			S_FIN: begin
				if (!out_vld_q || !result_stall) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.status = st_q;
	end

	assign out_vld_d = cmd.finish | (out_vld_q & result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			st_q      <= olis_pkg::ST_OK;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			st_q      <= st_d;
			out_vld_q <= out_vld_d;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_vld_q;

endmodule

// File: sv/olis_dp.sv
module olis_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  olis_pkg::item_t    item,
	input  olis_pkg::dp_cmd_t  cmd,
	output olis_pkg::dp_stat_t stat,
	output olis_pkg::result_t  result
);

	typedef enum logic [1:0] {
		K_MOVE = 2'd0,
		K_CAP  = 2'd1,
		K_CMP  = 2'd2
	} kind_t;

	logic [olis_pkg::ACT_W-1:0] act_q;
	logic [olis_pkg::POS_W-1:0] pos_q;
	logic [olis_pkg::VAL_W-1:0] val_q;

	logic [olis_pkg::CNT_W-1:0] cnt_q;
	logic [olis_pkg::CNT_W-1:0] idx_q;
	logic                       bank_q;

	logic [olis_pkg::VAL_W-1:0] mem_a [olis_pkg::CAPACITY];
	logic [olis_pkg::VAL_W-1:0] mem_b [olis_pkg::CAPACITY];
	logic [olis_pkg::VAL_W-1:0] rd_a_s1, rd_b_s1;

	logic                        vld_s1;
	kind_t                       kind_s1;
	logic [olis_pkg::ADDR_W-1:0] dst_s1;
	logic                        tgt_s1;
	logic                        bank_s1;
	logic [olis_pkg::POS_W-1:0]  k_s1;
	logic [olis_pkg::VAL_W-1:0]  rd_data;

	logic [olis_pkg::VAL_W-1:0] vout_q;
	logic                       found_q;
	logic [olis_pkg::POS_W-1:0] fpos_q;
	olis_pkg::result_t          res_q;

	logic [olis_pkg::CNT_W-1:0] pos_ext, half, kh, n, src, dst;
	kind_t                      kind;
	logic                       tgt;

	logic                        wr_move, wr_en, wr_bank;
	logic [olis_pkg::ADDR_W-1:0] wr_addr, rd_addr;
	logic [olis_pkg::VAL_W-1:0]  wr_data;

	assign pos_ext = olis_pkg::CNT_W'(pos_q);
	assign half    = cnt_q >> 1;
	assign kh      = idx_q >> 1;

	// sweep length and per-step addresses
	always_comb begin
		n    = olis_pkg::CNT_W'(1);
		src  = '0;
		dst  = '0;
		kind = K_CAP;
		tgt  = bank_q;
		case (act_q)
			olis_pkg::ACT_INSERT: begin
				n    = cnt_q - pos_ext;
				src  = cnt_q - idx_q - olis_pkg::CNT_W'(1);
				dst  = cnt_q - idx_q;
				kind = K_MOVE;
			end
			olis_pkg::ACT_REMOVE: begin
				n    = cnt_q - pos_ext;
				src  = pos_ext + idx_q;
				dst  = src - olis_pkg::CNT_W'(1);
				kind = (idx_q == '0) ? K_CAP : K_MOVE;
			end
			olis_pkg::ACT_REMOVE_LAST: begin
				src = cnt_q - olis_pkg::CNT_W'(1);
			end
			olis_pkg::ACT_READ: begin
				src = pos_ext;
			end
			olis_pkg::ACT_SEARCH: begin
				n    = cnt_q;
				src  = idx_q;
				kind = K_CMP;
			end
			olis_pkg::ACT_SHUFFLE: begin
				// odd leftover: last even step lands on count-1 itself
				n    = cnt_q;
				src  = idx_q[0] ? kh : (half + kh);
				dst  = idx_q;
				kind = K_MOVE;
				tgt  = ~bank_q;
			end
			default: begin
				n = olis_pkg::CNT_W'(1);
			end
		endcase
	end

	assign rd_addr = olis_pkg::ADDR_W'(src);
	assign rd_data = bank_s1 ? rd_b_s1 : rd_a_s1;

	assign wr_move = vld_s1 && (kind_s1 == K_MOVE);
	assign wr_en   = wr_move || cmd.single_wr;
	assign wr_bank = wr_move ? tgt_s1 : bank_q;
	assign wr_data = wr_move ? rd_data : val_q;
	always_comb begin
		if (wr_move) wr_addr = dst_s1;
		else if (act_q == olis_pkg::ACT_APPEND) wr_addr = cnt_q[olis_pkg::ADDR_W-1:0];
		else wr_addr = olis_pkg::ADDR_W'(pos_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) mem_a[wr_addr] <= wr_data;
		if (cmd.issue) rd_a_s1 <= mem_a[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_bank) mem_b[wr_addr] <= wr_data;
		if (cmd.issue) rd_b_s1 <= mem_b[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= item.action;
			pos_q <= item.position_in;
			val_q <= item.value_in;
		end
		if (cmd.issue) begin
			kind_s1 <= kind;
			dst_s1  <= olis_pkg::ADDR_W'(dst);
			tgt_s1  <= tgt;
			bank_s1 <= bank_q;
			k_s1    <= olis_pkg::POS_W'(idx_q);
		end
		if (cmd.load) begin
			vout_q  <= '0;
			found_q <= 1'b0;
			fpos_q  <= '0;
		end else if (vld_s1) begin
			if (kind_s1 == K_CAP) vout_q <= rd_data;
			if (kind_s1 == K_CMP && !found_q && rd_data == val_q) begin
				found_q <= 1'b1;
				fpos_q  <= k_s1;
			end
		end
		if (cmd.finish) begin
			res_q.value_out    <= vout_q;
			res_q.found        <= found_q;
			res_q.position_out <= fpos_q;
			res_q.count_out    <= cnt_q;
			res_q.status       <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			bank_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.load) idx_q <= '0;
			else if (cmd.issue) idx_q <= idx_q + olis_pkg::CNT_W'(1);
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + olis_pkg::CNT_W'(1);
			else if (cmd.cnt_dec) cnt_q <= cnt_q - olis_pkg::CNT_W'(1);
			if (cmd.flip) bank_q <= ~bank_q;
		end
	end

	assign stat.act   = act_q;
	assign stat.full  = (cnt_q == olis_pkg::CNT_W'(olis_pkg::CAPACITY));
	assign stat.empty = (cnt_q == '0);
	assign stat.range = (pos_ext >= cnt_q);
	assign stat.few   = (cnt_q < olis_pkg::CNT_W'(2));
	assign stat.last  = (idx_q == n - olis_pkg::CNT_W'(1));

	assign result = res_q;

endmodule

// File: sv/ordered_list_with_in_shuffle.sv
// Each item is decoded first; a status-only or empty action then finishes, append and write do a
// single write, read and remove last read one entry, remove sweeps count-position entries, insert
// sweeps count-position entries then writes, search and shuffle sweep count entries; the sweep
// reads one entry per cycle. The next item is taken once the result is stored.
// Reset (arst_n low, asynchronous): list empty, no result pending; entry storage is not cleared.
module ordered_list_with_in_shuffle (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  olis_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output olis_pkg::result_t result
);

	// Controller sequences each action: decode against count and position, sweep the entry
	// memory one address per cycle where entries must be read or moved, drain the read pipeline, do a
	// single write where needed, then hold the result until the output register is free.
	olis_pkg::dp_cmd_t  cmd;
	olis_pkg::dp_stat_t stat;

	olis_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	// Datapath holds the item, the count, two entry banks (shuffle copies into the idle bank
	// and then swaps banks), the one-stage read pipeline and the result register.
	olis_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

// File: bench/testbench.sv
module testbench;
	import olis_pkg::*;

	// Quiet-cycle budget for the watchdog. The longest correct wait is the receiver
	// hold-off plus one full-list sweep, so this leaves ample margin.
	localparam int QUIET_LIMIT = 2000;
	// Length of the forced receiver hold-off used to back the list up.
	localparam int HOLD_LEN    = 300;
	// Items per random phase.
	localparam int PHASE_ITEMS = 160;
	localparam int NUM_PHASES  = 5;

	// Predicts the list contents and the result of every accepted action, and keeps
	// the predicted results in order until the block returns them.
	class list_scoreboard;
		logic [VAL_W-1:0] slots [CAPACITY];
		int unsigned      fill;
		result_t          expected_q [$];
		int               errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		function void note(item_t it);
			result_t          r;
			logic [VAL_W-1:0] tmp [CAPACITY];
			int unsigned      half;
			int unsigned      i;
			r        = '0;
			r.status = ST_OK;
			case (it.action)
				ACT_APPEND: begin
					if (fill >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						slots[fill] = it.value_in;
						fill++;
					end
				end
				ACT_INSERT: begin
					if (fill >= CAPACITY) begin
						r.status = ST_FULL;
					end else if (it.position_in >= fill) begin
						r.status = ST_RANGE;
					end else begin
						for (i = fill; i > it.position_in; i--)
							slots[i] = slots[i-1];
						slots[it.position_in] = it.value_in;
						fill++;
					end
				end
				ACT_REMOVE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else if (it.position_in >= fill) begin
						r.status = ST_RANGE;
					end else begin
						r.value_out = slots[it.position_in];
						for (i = it.position_in; i + 1 < fill; i++)
							slots[i] = slots[i+1];
						fill--;
					end
				end
				ACT_REMOVE_LAST: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						fill--;
						r.value_out = slots[fill];
					end
				end
				ACT_READ: begin
					if (fill == 0)
						r.status = ST_EMPTY;
					else if (it.position_in >= fill)
						r.status = ST_RANGE;
					else
						r.value_out = slots[it.position_in];
				end
				ACT_WRITE: begin
					if (fill == 0)
						r.status = ST_EMPTY;
					else if (it.position_in >= fill)
						r.status = ST_RANGE;
					else
						slots[it.position_in] = it.value_in;
				end
				ACT_SEARCH: begin
					for (i = 0; i < fill; i++) begin
						if (!r.found && slots[i] == it.value_in) begin
							r.found        = 1'b1;
							r.position_out = POS_W'(i);
						end
					end
				end
				ACT_SHUFFLE: begin
					if (fill >= 2) begin
						half = fill / 2;
						for (i = 0; i < half; i++) begin
							tmp[2*i]   = slots[half+i];
							tmp[2*i+1] = slots[i];
						end
						if (fill[0])
							tmp[fill-1] = slots[fill-1];
						for (i = 0; i < fill; i++)
							slots[i] = tmp[i];
					end
				end
				ACT_CLEAR: fill = 0;
				default: ;
			endcase
			r.count_out = CNT_W'(fill);
			expected_q.push_back(r);
		endfunction

		function void check(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, got %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.value_out !== want.value_out) begin
				$display("%0t: value_out expected %0h got %0h", $time,
					want.value_out, got.value_out);
				errors++;
			end
			if (got.found !== want.found) begin
				$display("%0t: found expected %0b got %0b", $time, want.found, got.found);
				errors++;
			end
			if (got.position_out !== want.position_out) begin
				$display("%0t: position_out expected %0d got %0d", $time,
					want.position_out, got.position_out);
				errors++;
			end
			if (got.count_out !== want.count_out) begin
				$display("%0t: count_out expected %0d got %0d", $time,
					want.count_out, got.count_out);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	list_scoreboard sb = new();

	// Idle odds in percent for each side; the receiver's copy is updated with a
	// nonblocking write so its process never races the stimulus process.
	int   tx_pct     = 0;
	int   rx_pct     = 0;
	logic hold_now   = 1'b0;
	int   hold_count = 0;
	int   quiet_cycles = 0;

	ordered_list_with_in_shuffle dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: check every result transfer, then pick the stall for the next cycle.
	// A requested hold-off is counted here, one cycle at a time, and overrides the
	// random stall until it runs out.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check(result);
		if (hold_now && hold_count < HOLD_LEN) begin
			result_stall <= 1'b1;
			hold_count++;
		end else begin
			result_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
		end
	end

	// Watchdog: give up once nothing has moved on either channel for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic item_t mk(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		item_t it;
		it.action      = act;
		it.position_in = pos;
		it.value_in    = val;
		return it;
	endfunction

	// Draw one action. Size-changing actions steer the list toward the phase target
	// so that both the full and the empty list get visited; most positions land
	// inside the list and most searches look for a value that is really there.
	function automatic item_t pick_item(int unsigned target);
		item_t       it;
		int unsigned roll;
		it.value_in    = VAL_W'($urandom);
		it.position_in = POS_W'($urandom);
		if (sb.fill > 0 && $urandom_range(99) < 85)
			it.position_in = POS_W'($urandom_range(sb.fill - 1));
		roll = $urandom_range(99);
		if (roll < 3) begin
			// unused codes above clear
			it.action = ACT_CLEAR + ACT_W'($urandom_range(1, 7));
		end else if (roll < 55) begin
			if (sb.fill < target)
				it.action = ($urandom_range(99) < 70) ? ACT_APPEND : ACT_INSERT;
			else if (sb.fill > target)
				it.action = $urandom_range(1) ? ACT_REMOVE : ACT_REMOVE_LAST;
			else
				it.action = $urandom_range(1) ? ACT_APPEND : ACT_INSERT;
		end else if (roll < 68) begin
			it.action = ACT_READ;
		end else if (roll < 78) begin
			it.action = ACT_WRITE;
		end else if (roll < 90) begin
			it.action = ACT_SEARCH;
			if (sb.fill > 0 && $urandom_range(99) < 70)
				it.value_in = sb.slots[$urandom_range(sb.fill - 1)];
		end else if (roll < 98) begin
			it.action = ACT_SHUFFLE;
		end else begin
			it.action = ACT_CLEAR;
		end
		return it;
	endfunction

	// Offer one item, hold it until the transfer, record it, then idle the sender
	// for a random number of cycles. Valid is only dropped when a gap follows, so a
	// back-to-back item keeps valid high without a second write in the same step.
	task automatic send_item(input item_t it);
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note(it);
		while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		int          phase;
		int          n;
		int unsigned target;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every action but clear on an empty list, then a short hand-built list that
		// walks through range errors, found and missing searches, odd and even
		// shuffles, the unused codes and clear.
		send_item(mk(ACT_REMOVE_LAST, 6'd0, 8'h00));
		send_item(mk(ACT_REMOVE, 6'd0, 8'h00));
		send_item(mk(ACT_READ, 6'd0, 8'h00));
		send_item(mk(ACT_WRITE, 6'd0, 8'hFF));
		send_item(mk(ACT_INSERT, 6'd0, 8'hFF));
		send_item(mk(ACT_SEARCH, 6'd0, 8'h00));
		send_item(mk(ACT_SHUFFLE, 6'd0, 8'h00));
		send_item(mk(ACT_APPEND, 6'd63, 8'h00));
		send_item(mk(ACT_SHUFFLE, 6'd0, 8'h00));
		send_item(mk(ACT_APPEND, 6'd0, 8'hFF));
		send_item(mk(ACT_INSERT, 6'd0, 8'hA5));
		send_item(mk(ACT_READ, 6'd63, 8'h00));
		send_item(mk(ACT_READ, 6'd3, 8'h00));
		send_item(mk(ACT_WRITE, 6'd2, 8'h5A));
		send_item(mk(ACT_REMOVE, 6'd63, 8'h00));
		send_item(mk(ACT_APPEND, 6'd0, 8'hFF));
		send_item(mk(ACT_SEARCH, 6'd0, 8'hFF));
		send_item(mk(ACT_SEARCH, 6'd63, 8'h77));
		send_item(mk(ACT_SHUFFLE, 6'd0, 8'h00));
		send_item(mk(ACT_APPEND, 6'd0, 8'h3C));
		send_item(mk(ACT_SHUFFLE, 6'd0, 8'h00));
		send_item(mk(ACT_REMOVE, 6'd0, 8'h00));
		send_item(mk(ACT_REMOVE_LAST, 6'd0, 8'h00));
		send_item(mk(ACT_CLEAR + 4'd1, 6'd63, 8'hFF));
		send_item(mk(ACT_CLEAR + 4'd7, 6'd21, 8'h96));
		send_item(mk(ACT_CLEAR, 6'd0, 8'h00));
		send_item(mk(ACT_REMOVE_LAST, 6'd0, 8'h00));

		// Random phases: no idling toward a full list, sender gaps while draining,
		// receiver stalls while refilling, both idling at a random level, and last
		// a long receiver hold-off with the sender pushing back to back.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin tx_pct = 0;  rx_pct <= 0;  target = CAPACITY; end
				1: begin tx_pct = 73; rx_pct <= 0;  target = 0; end
				2: begin tx_pct = 0;  rx_pct <= 73; target = CAPACITY; end
				3: begin tx_pct = 35; rx_pct <= 35; target = $urandom_range(CAPACITY); end
				default: begin
					tx_pct = 0;
					rx_pct <= 0;
					hold_now <= 1'b1;
					target = $urandom_range(CAPACITY);
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				send_item(pick_item(target));
		end
		item_valid <= 1'b0;

		// Drain: wait for every predicted result, then watch a while longer for
		// anything extra.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
